FILE: hdl/atba_pkg.sv
package atba_pkg;

    localparam int OP_W       = 3;
    localparam int SEL_W      = 4;
    localparam int CNT_W      = 32;
    localparam int ALIGN_W    = 4;
    localparam int STATUS_W   = 2;
    localparam int ADDR_W     = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;

    localparam logic [OP_W-1:0] OP_COMMIT   = 3'd0;
    localparam logic [OP_W-1:0] OP_DECOMMIT = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH     = 3'd2;
    localparam logic [OP_W-1:0] OP_PULL     = 3'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ARENA_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'b1;

    localparam logic [CNT_W-1:0]  ARENA_BYTES_RST = 32'd4096;
    localparam logic [ADDR_W-1:0] REGION_BASE_RST = 48'd0;

endpackage

FILE: hdl/atba_req_if.sv
interface atba_req_if;
    logic                            valid;
    logic                            ready;
    logic [atba_pkg::OP_W-1:0]       op;
    logic [atba_pkg::SEL_W-1:0]      arena_sel;
    logic [atba_pkg::CNT_W-1:0]      byte_count;
    logic [atba_pkg::ALIGN_W-1:0]    align_log2;

    modport source(output valid, op, arena_sel, byte_count, align_log2, input ready);
    modport sink(input valid, op, arena_sel, byte_count, align_log2, output ready);
endinterface

FILE: hdl/atba_rsp_if.sv
interface atba_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [atba_pkg::STATUS_W-1:0]   status;
    logic [atba_pkg::SEL_W-1:0]      arena_out;
    logic [atba_pkg::ADDR_W-1:0]     address;
    logic [atba_pkg::CNT_W-1:0]      used_bytes;
    logic [atba_pkg::CNT_W-1:0]      free_bytes;

    modport source(output valid, status, arena_out, address, used_bytes, free_bytes,
                   input ready);
    modport sink(input valid, status, arena_out, address, used_bytes, free_bytes,
                 output ready);
endinterface

FILE: hdl/atba_ram.sv
module atba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hdl/atba_first_free.sv
module atba_first_free #(
    parameter int N  = 16,
    parameter int IW = 4
) (
    input  logic [N-1:0]  i_committed,
    output logic          o_any,
    output logic [IW-1:0] o_idx
);
    // lowest clear bit wins: scan from the top so the last hit is the lowest
    always_comb begin
        o_any = 1'b0;
        o_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!i_committed[i]) begin
                o_any = 1'b1;
                o_idx = IW'(i);
            end
        end
    end
endmodule

FILE: hdl/arena_table_bump_allocator.sv
// Each accepted item passes in order through accept and read of the position
// memory (S_IDLE), compute (S_CALC), and write back and load of the result
// register (S_WB); a new item is taken only once the last write-back is done. A
// result not taken holds the write-back stage until the sink takes it.
// Reset (synchronous, active low): all arenas uncommitted, all positions
// read as zero through per-entry valid bits, registers at their defaults.
module arena_table_bump_allocator #(
    parameter int NUM_ARENAS = 16,
    parameter int ADDR_BITS  = 48
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    atba_req_if.sink                           i_req,
    atba_rsp_if.source                         o_rsp,
    input  logic                               i_cfg_we,
    input  logic [atba_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [atba_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    localparam int IW = $clog2(NUM_ARENAS);
    localparam int AW = atba_pkg::ADDR_W;
    localparam int CW = atba_pkg::CNT_W;
    localparam logic [AW-1:0] AMASK =
        (ADDR_BITS >= AW) ? {AW{1'b1}} : ((AW'(1) << ADDR_BITS) - AW'(1));

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_WB   = 3'b100
    } t_state;

    typedef struct packed {
        logic wr_mem;
        logic set_commit;
        logic clr_commit;
        logic clr_pval;
    } t_upd;

    t_state r_state, n_state;

    logic [CW-1:0]         r_arena_bytes;
    logic [AW-1:0]         r_region_base;
    logic [NUM_ARENAS-1:0] r_committed;
    logic [NUM_ARENAS-1:0] r_pvalid;

    // accepted item
    logic [atba_pkg::OP_W-1:0]  r_op;
    logic [atba_pkg::SEL_W-1:0] r_sel;
    logic [IW-1:0]              r_idx;
    logic                       r_inrange;
    logic [CW:0]                r_rounded;
    logic                       r_any;
    logic [IW-1:0]              r_cidx;

    // computed, waiting for write-back
    logic [atba_pkg::STATUS_W-1:0] r_status;
    logic [atba_pkg::SEL_W-1:0]    r_arena;
    logic [CW-1:0]                 r_newpos;
    logic                          r_addr_en;
    logic                          r_zero;
    logic [AW-1:0]                 r_prod;
    logic [AW-1:0]                 r_addend;
    logic [IW-1:0]                 r_tgt;
    t_upd                          r_upd;

    // result register
    logic                          r_ovalid;
    logic [atba_pkg::STATUS_W-1:0] r_o_status;
    logic [atba_pkg::SEL_W-1:0]    r_o_arena;
    logic [AW-1:0]                 r_o_addr;
    logic [CW-1:0]                 r_o_used;
    logic [CW-1:0]                 r_o_free;

    logic          accept;
    logic          wb_go;
    logic          ff_any;
    logic [IW-1:0] ff_idx;
    logic [CW:0]   amask;
    logic [CW:0]   rounded;
    logic [IW-1:0] rd_addr;
    logic [CW-1:0] ram_rdata;

    logic [CW-1:0]                 cur;
    logic [CW+1:0]                 nxt;
    logic                          fits;
    logic [CW-1:0]                 pulled;
    logic [IW-1:0]                 calc_idx;
    logic [atba_pkg::STATUS_W-1:0] c_status;
    logic [atba_pkg::SEL_W-1:0]    c_arena;
    logic [CW-1:0]                 c_newpos;
    logic                          c_addr_en;
    logic                          c_zero;
    logic [AW-1:0]                 c_addend;
    t_upd                          c_upd;

    logic [AW-1:0] wb_addr;
    logic [CW-1:0] wb_free;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && (r_state == S_IDLE);
    assign wb_go       = (r_state == S_WB) && (!r_ovalid || o_rsp.ready);

    atba_first_free #(.N(NUM_ARENAS), .IW(IW)) u_first_free (
        .i_committed (r_committed),
        .o_any       (ff_any),
        .o_idx       (ff_idx)
    );

    // round the count up to the alignment
    always_comb begin
        amask   = ((CW+1)'(1) << i_req.align_log2) - (CW+1)'(1);
        rounded = ({1'b0, i_req.byte_count} + amask) & ~amask;
    end

    // hold the read address through compute so the read data stays put
    assign rd_addr = (r_state == S_IDLE) ? IW'(i_req.arena_sel) : r_idx;

    atba_ram #(.WIDTH(CW), .DEPTH(NUM_ARENAS)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (wb_go && r_upd.wr_mem),
        .i_waddr (r_tgt),
        .i_wdata (r_newpos),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        cur      = (r_inrange && r_pvalid[r_idx]) ? ram_rdata : '0;
        nxt      = (CW+2)'(cur) + (CW+2)'(r_rounded);
        fits     = r_inrange && r_committed[r_idx] && (nxt <= (CW+2)'(r_arena_bytes));
        pulled   = (r_rounded >= (CW+1)'(cur)) ? '0 : cur - r_rounded[CW-1:0];
        calc_idx = (r_op == atba_pkg::OP_COMMIT) ? r_cidx : r_idx;

        c_status  = atba_pkg::ST_OK;
        c_arena   = r_sel;
        c_newpos  = cur;
        c_addr_en = 1'b0;
        c_zero    = 1'b0;
        c_addend  = r_region_base;
        c_upd     = '0;

        if (r_op == atba_pkg::OP_COMMIT) begin
            if (r_any) begin
                c_arena        = atba_pkg::SEL_W'(r_cidx);
                c_newpos       = '0;
                c_addr_en      = 1'b1;
                c_upd.set_commit = 1'b1;
                c_upd.clr_pval   = 1'b1;
            end else begin
                c_status = atba_pkg::ST_NONE_FREE;
                c_arena  = '0;
                c_zero   = 1'b1;
            end
        end else if (!r_inrange) begin
            c_zero = 1'b1;
        end else begin
            case (r_op)
                atba_pkg::OP_DECOMMIT: begin
                    c_newpos         = '0;
                    c_upd.clr_commit = 1'b1;
                    c_upd.clr_pval   = 1'b1;
                end
                atba_pkg::OP_PUSH: begin
                    if (fits) begin
                        c_newpos     = nxt[CW-1:0];
                        c_addr_en    = 1'b1;
                        c_addend     = r_region_base + AW'(cur);
                        c_upd.wr_mem = 1'b1;
                    end else begin
                        c_status = atba_pkg::ST_NO_FIT;
                    end
                end
                atba_pkg::OP_PULL: begin
                    c_newpos     = pulled;
                    c_upd.wr_mem = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        wb_addr = r_addr_en ? ((r_prod + r_addend) & AMASK) : '0;
        if (r_zero || r_newpos >= r_arena_bytes) begin
            wb_free = '0;
        end else begin
            wb_free = r_arena_bytes - r_newpos;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_CALC;
            S_CALC: n_state = S_WB;
            S_WB:   if (wb_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_arena_bytes <= atba_pkg::ARENA_BYTES_RST;
            r_region_base <= atba_pkg::REGION_BASE_RST;
            r_committed   <= '0;
            r_pvalid      <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    atba_pkg::CFG_ARENA_BYTES: r_arena_bytes <= i_cfg_wdata[CW-1:0];
                    atba_pkg::CFG_REGION_BASE: r_region_base <= i_cfg_wdata[AW-1:0];
                    default: begin
                    end
                endcase
            end
            if (wb_go) begin
                if (r_upd.set_commit) r_committed[r_tgt] <= 1'b1;
                if (r_upd.clr_commit) r_committed[r_tgt] <= 1'b0;
                if (r_upd.clr_pval)   r_pvalid[r_tgt]    <= 1'b0;
                if (r_upd.wr_mem)     r_pvalid[r_tgt]    <= 1'b1;
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= i_req.op;
            r_sel     <= i_req.arena_sel;
            r_idx     <= IW'(i_req.arena_sel);
            r_inrange <= (32'(i_req.arena_sel) < 32'(NUM_ARENAS));
            r_rounded <= rounded;
            r_any     <= ff_any;
            r_cidx    <= ff_idx;
        end
        if (r_state == S_CALC) begin
            r_status  <= c_status;
            r_arena   <= c_arena;
            r_newpos  <= c_newpos;
            r_addr_en <= c_addr_en;
            r_zero    <= c_zero;
            r_prod    <= AW'(r_arena_bytes) * AW'(calc_idx);
            r_addend  <= c_addend;
            r_tgt     <= calc_idx;
            r_upd     <= c_upd;
        end
        if (wb_go) begin
            r_o_status <= r_status;
            r_o_arena  <= r_arena;
            r_o_addr   <= wb_addr;
            r_o_used   <= r_zero ? '0 : r_newpos;
            r_o_free   <= wb_free;
        end
    end

    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.arena_out  = r_o_arena;
    assign o_rsp.address    = r_o_addr;
    assign o_rsp.used_bytes = r_o_used;
    assign o_rsp.free_bytes = r_o_free;

endmodule
